FILE: design/cfca_pkg.sv
// cfca_pkg: beat types, frame constants and CRC-16 helper functions for the
// command frame CRC appender. No dependencies; used by the top level and its checker.
package cfca_pkg;

	// Input beat: one command byte and its end-of-command mark
	typedef struct packed {
		logic [7:0] cmd_byte;
		logic       last_byte;
	} in_beat_t;

	// Output beat: one framed byte and the closing-terminator mark
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_beat_t;

	// Which part of a frame tail the output side is sending
	typedef enum logic [1:0] {
		BEAT_DATA,
		BEAT_CRC_HI,
		BEAT_CRC_LO,
		BEAT_TERM
	} beat_sel_t;

	localparam logic [7:0] FRAME_TERM = 8'h0D;
	localparam logic [7:0] ESC_PAREN  = 8'h28;
	localparam logic [7:0] ESC_CR     = 8'h0D;
	localparam logic [7:0] ESC_LF     = 8'h0A;

	// Remainders of polynomial 0x1021 for each top nibble
	localparam logic [15:0] NIBBLE_TAB [16] = '{
		16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
		16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
	};

	// Absorb one nibble, MSB first
	function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
		logic [3:0] idx;
		idx = crc[15:12] ^ nib;
		return {crc[11:0], 4'h0} ^ NIBBLE_TAB[idx];
	endfunction

	// Absorb one byte as two nibble steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] mid;
		mid = crc_nibble(crc, b[7:4]);
		return crc_nibble(mid, b[3:0]);
	endfunction

	// Raise a CRC byte by one where it would collide with a framing character
	function automatic logic [7:0] escape_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b inside {ESC_PAREN, ESC_CR, ESC_LF}) begin
			r = b + 8'd1;
		end
		return r;
	endfunction

endpackage

FILE: design/command_frame_crc_appender.sv
// command_frame_crc_appender: passes command bytes through and closes each
// command with its CRC-16 (XMODEM) bytes and a carriage return. Uses cfca_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid / in_ready     | cfca_pkg::in_beat_t  in_beat
//   out     | output    | out_valid / out_ready   | cfca_pkg::out_beat_t out_beat
//
// A byte that is not last yields one output beat; a last byte yields four beats (byte,
// CRC high, CRC low, terminator) through the single output port. The CRC is updated as
// a byte is taken, so bytes may arrive every cycle while no stall or frame tail holds them.
// Reset clears the running CRC and empties the input stage and output register.
// A stalled output holds its beat; the input stage refills as soon as its last beat
// moves to the output register.
module command_frame_crc_appender (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfca_pkg::in_beat_t  in_beat,
	output logic                out_valid,
	input  logic                out_ready,
	output cfca_pkg::out_beat_t out_beat
);

	logic [15:0]         crc_q;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic [7:0]          crc_hi_s1;
	logic [7:0]          crc_lo_s1;
	cfca_pkg::beat_sel_t sel_q;
	cfca_pkg::beat_sel_t sel_next;
	logic                out_valid_q;
	cfca_pkg::out_beat_t out_beat_q;
	cfca_pkg::out_beat_t beat_mux;

	logic        in_take;
	logic        load_out;
	logic        s1_done;
	logic [15:0] crc_next;

	// Handshake between the input stage and the output register
	assign load_out = valid_s1 && (!out_valid_q || out_ready);
	assign s1_done  = load_out && (!last_s1 || sel_q == cfca_pkg::BEAT_TERM);
	assign in_ready = !valid_s1 || s1_done;
	assign in_take  = in_valid && in_ready;
	assign crc_next = cfca_pkg::crc_byte(crc_q, in_beat.cmd_byte);

	// Pick the beat to send and the tail position after it
	always_comb begin
		beat_mux = '0;
		sel_next = cfca_pkg::BEAT_DATA;
		case (sel_q)
			cfca_pkg::BEAT_DATA: begin
				beat_mux.out_byte = byte_s1;
				sel_next          = cfca_pkg::BEAT_CRC_HI;
			end
			cfca_pkg::BEAT_CRC_HI: begin
				beat_mux.out_byte = crc_hi_s1;
				sel_next          = cfca_pkg::BEAT_CRC_LO;
			end
			cfca_pkg::BEAT_CRC_LO: begin
				beat_mux.out_byte = crc_lo_s1;
				sel_next          = cfca_pkg::BEAT_TERM;
			end
			cfca_pkg::BEAT_TERM: begin
				beat_mux.out_byte  = cfca_pkg::FRAME_TERM;
				beat_mux.frame_end = 1'b1;
				sel_next           = cfca_pkg::BEAT_DATA;
			end
			default: begin
				beat_mux = '0;
				sel_next = cfca_pkg::BEAT_DATA;
			end
		endcase
	end

	// Advance the running CRC; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (in_take) begin
			crc_q <= in_beat.last_byte ? 16'h0000 : crc_next;
		end
	end

	// Input stage valid and tail position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sel_q    <= cfca_pkg::BEAT_DATA;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (s1_done) begin
				sel_q <= cfca_pkg::BEAT_DATA;
			end else if (load_out) begin
				sel_q <= sel_next;
			end
		end
	end

	// Capture the byte and the escaped CRC bytes of the frame
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1   <= in_beat.cmd_byte;
			last_s1   <= in_beat.last_byte;
			crc_hi_s1 <= cfca_pkg::escape_byte(crc_next[15:8]);
			crc_lo_s1 <= cfca_pkg::escape_byte(crc_next[7:0]);
		end
	end

	// Output register: load a new beat or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_beat_q <= beat_mux;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule

FILE: design/cfca_checker.sv
// cfca_checker: port-level checks for command_frame_crc_appender, bound to the
// top level below. Uses cfca_pkg for beat types and the terminator constant.
module cfca_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input cfca_pkg::in_beat_t  in_beat,
	input logic                out_valid,
	input logic                out_ready,
	input cfca_pkg::out_beat_t out_beat
);

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_beat))
		else $error("output beat changed while stalled");

	// Close every frame with the carriage return
	a_term_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.frame_end |-> out_beat.out_byte == cfca_pkg::FRAME_TERM)
		else $error("frame end without terminator byte");

	// Show no beat once reset has been seen at an edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind command_frame_crc_appender cfca_checker u_cfca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_beat   (in_beat),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_beat  (out_beat)
);
